>>> hdl/utf8_codepoint_decoder_macros.svh
// Assertion macros shared by the UTF-8 code point decoder modules.
`ifndef UTF8_CODEPOINT_DECODER_MACROS_SVH
`define UTF8_CODEPOINT_DECODER_MACROS_SVH

`ifndef SYNTHESIS
// Checks that the consequence holds in the same cycle as the antecedent.
`define UCD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("utf8 decoder: same-cycle check failed");
// Checks that the consequence holds in the cycle after the antecedent.
`define UCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("utf8 decoder: next-cycle check failed");
`else
`define UCD_ASSERT_SAME(label, ante, cons)
`define UCD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> hdl/utf8cd_pkg.sv
// Shared types, constants and helper functions of the UTF-8 code point decoder.
package utf8cd_pkg;

    localparam int CP_W        = 21;
    localparam int CP1_W       = 11;
    localparam int CP2_W       = 7;
    localparam int NRES_W      = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CP_W-1:0]  BAD_CP    = 21'h00003F;
    localparam logic [CP2_W-1:0] BAD_CP_LO = 7'h3F;

    // Input transaction.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_t;

    // Result transaction.
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            run_end;
        logic            text_done;
    } out_t;

    // One queue entry: all results caused by one input byte.
    typedef struct packed {
        logic [NRES_W-1:0] num_results;
        logic [CP_W-1:0]   cp0;
        logic [CP1_W-1:0]  cp1;
        logic [CP2_W-1:0]  cp2;
        logic              eot;
    } entry_t;

    // Number of following bytes a lead byte calls for; zero if not a lead.
    function automatic logic [1:0] follow_len(logic [7:0] c);
        logic [1:0] len;
        if (c[7:5] == 3'b110) begin
            len = 2'd1;
        end else if (c[7:4] == 4'b1110) begin
            len = 2'd2;
        end else if (c[7:3] == 5'b11110) begin
            len = 2'd3;
        end else begin
            len = 2'd0;
        end
        return len;
    endfunction

    // Code point of a byte that has nothing after it: ASCII or the replacement.
    function automatic logic [CP2_W-1:0] single_cp(logic [7:0] c);
        return c[7] ? BAD_CP_LO : c[6:0];
    endfunction

endpackage

>>> hdl/utf8cd_front.sv
// Front end: accepts bytes, tracks the open sequence and builds queue entries.
`include "utf8_codepoint_decoder_macros.svh"

module utf8cd_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  utf8cd_pkg::in_t     s_data,
    output logic                push_valid,
    input  logic                push_ready,
    output utf8cd_pkg::entry_t  push_entry
);

    logic                seq_open_reg, seq_open_next;
    logic [7:0]          lead_reg, lead_next;
    logic [1:0]          held_count_reg, held_count_next;
    logic [7:0]          held_reg [2];
    logic [7:0]          held_next [2];
    logic                accept;
    logic                has_result;
    logic [1:0]          lead_len;
    logic [7:0]          b;
    logic                eot;
    utf8cd_pkg::entry_t  entry;

    assign b        = s_data.text_byte;
    assign eot      = s_data.end_of_text;
    assign lead_len = utf8cd_pkg::follow_len(lead_reg);

    // A byte is taken only while the queue has a free slot, whether or not it gives a result.
    assign s_ready    = push_ready;
    assign accept     = s_valid && s_ready;
    assign push_valid = s_valid && has_result;
    assign push_entry = entry;

    // Decode the byte against the open sequence.
    always_comb begin
        entry            = '0;
        entry.eot        = eot;
        has_result       = 1'b0;
        seq_open_next    = seq_open_reg;
        lead_next        = lead_reg;
        held_count_next  = held_count_reg;
        held_next[0]     = held_reg[0];
        held_next[1]     = held_reg[1];
        if (!seq_open_reg) begin
            if (!b[7]) begin
                has_result        = 1'b1;
                entry.num_results = 2'd1;
                entry.cp0         = {14'd0, b[6:0]};
            end else if (utf8cd_pkg::follow_len(b) == 2'd0 || eot) begin
                has_result        = 1'b1;
                entry.num_results = 2'd1;
                entry.cp0         = utf8cd_pkg::BAD_CP;
            end else begin
                seq_open_next   = 1'b1;
                lead_next       = b;
                held_count_next = 2'd0;
            end
        end else if (({1'b0, held_count_reg} + 3'd1) >= {1'b0, lead_len}) begin
            // This byte completes the sequence.
            has_result        = 1'b1;
            entry.num_results = 2'd1;
            case (lead_len)
                2'd1:    entry.cp0 = {10'd0, lead_reg[4:0], b[5:0]};
                2'd2:    entry.cp0 = {5'd0, lead_reg[3:0], held_reg[0][5:0], b[5:0]};
                default: entry.cp0 = {lead_reg[2:0], held_reg[0][5:0], held_reg[1][5:0],
                                      b[5:0]};
            endcase
            seq_open_next   = 1'b0;
            lead_next       = 8'd0;
            held_count_next = 2'd0;
        end else if (eot) begin
            // Cut sequence: the lead is replaced, then the tail is decoded on its own.
            has_result = 1'b1;
            entry.cp0  = utf8cd_pkg::BAD_CP;
            if (held_count_reg == 2'd0) begin
                entry.num_results = 2'd2;
                entry.cp1         = {4'd0, utf8cd_pkg::single_cp(b)};
            end else if (!held_reg[0][7]) begin
                entry.num_results = 2'd3;
                entry.cp1         = {4'd0, held_reg[0][6:0]};
                entry.cp2         = utf8cd_pkg::single_cp(b);
            end else if (utf8cd_pkg::follow_len(held_reg[0]) == 2'd1) begin
                entry.num_results = 2'd2;
                entry.cp1         = {held_reg[0][4:0], b[5:0]};
            end else begin
                entry.num_results = 2'd3;
                entry.cp1         = {4'd0, utf8cd_pkg::BAD_CP_LO};
                entry.cp2         = utf8cd_pkg::single_cp(b);
            end
        end else begin
            held_next[held_count_reg[0]] = b;
            held_count_next              = held_count_reg + 2'd1;
        end
        // The final byte of a text always leaves the decoder idle.
        if (eot) begin
            seq_open_next   = 1'b0;
            lead_next       = 8'd0;
            held_count_next = 2'd0;
        end
    end

    // Sequence control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_open_reg   <= 1'b0;
            lead_reg       <= 8'd0;
            held_count_reg <= 2'd0;
        end else if (accept) begin
            seq_open_reg   <= seq_open_next;
            lead_reg       <= lead_next;
            held_count_reg <= held_count_next;
        end
    end

    // Collected continuation bytes.
    always_ff @(posedge aclk) begin
        if (accept) begin
            held_reg[0] <= held_next[0];
            held_reg[1] <= held_next[1];
        end
    end

    `UCD_ASSERT_SAME(a_open_lead_short, seq_open_reg, held_count_reg < lead_len)
    `UCD_ASSERT_NEXT(a_eot_goes_idle, accept && eot, !seq_open_reg)

endmodule

>>> hdl/utf8cd_queue.sv
// Small FIFO of decoded entries between the front and the back end.
`include "utf8_codepoint_decoder_macros.svh"

module utf8cd_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  utf8cd_pkg::entry_t  in_entry,
    output logic                out_valid,
    input  logic                out_pop,
    output utf8cd_pkg::entry_t  out_entry
);

    utf8cd_pkg::entry_t              mem [utf8cd_pkg::QUEUE_DEPTH];
    logic [utf8cd_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [utf8cd_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [utf8cd_pkg::QCNT_W-1:0]   count_reg, count_next;
    logic                            push;
    logic                            pop;

    assign in_ready  = count_reg != utf8cd_pkg::QCNT_W'(utf8cd_pkg::QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_entry = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    // Pointer and occupancy update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == utf8cd_pkg::QPTR_W'(utf8cd_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + utf8cd_pkg::QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == utf8cd_pkg::QPTR_W'(utf8cd_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + utf8cd_pkg::QPTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + utf8cd_pkg::QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - utf8cd_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_entry;
        end
    end

    `UCD_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= utf8cd_pkg::QCNT_W'(utf8cd_pkg::QUEUE_DEPTH))
    `UCD_ASSERT_SAME(a_empty_ptrs_equal, count_reg == '0, wr_ptr_reg == rd_ptr_reg)

endmodule

>>> hdl/utf8cd_back.sv
// Back end: expands each queue entry into its results through an output register.
`include "utf8_codepoint_decoder_macros.svh"

module utf8cd_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  utf8cd_pkg::entry_t  q_entry,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output utf8cd_pkg::out_t    m_data
);

    logic                        m_valid_reg;
    utf8cd_pkg::out_t            m_data_reg;
    logic [utf8cd_pkg::NRES_W-1:0] idx_reg;
    logic                        load;
    logic                        last;
    logic [utf8cd_pkg::CP_W-1:0] sel_cp;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign load    = q_valid && (!m_valid_reg || m_ready);
    assign last    = idx_reg == (q_entry.num_results - utf8cd_pkg::NRES_W'(1));
    assign q_pop   = load && last;

    // Pick the result at the current index of the head entry.
    always_comb begin
        case (idx_reg)
            2'd0:    sel_cp = q_entry.cp0;
            2'd1:    sel_cp = {{(utf8cd_pkg::CP_W - utf8cd_pkg::CP1_W){1'b0}}, q_entry.cp1};
            default: sel_cp = {{(utf8cd_pkg::CP_W - utf8cd_pkg::CP2_W){1'b0}}, q_entry.cp2};
        endcase
    end

    // Output valid and index within the head entry.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
            idx_reg     <= last ? '0 : idx_reg + utf8cd_pkg::NRES_W'(1);
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg.code_point <= sel_cp;
            m_data_reg.run_end    <= last;
            m_data_reg.text_done  <= last && q_entry.eot;
        end
    end

    `UCD_ASSERT_SAME(a_mid_entry_has_head, idx_reg != '0, q_valid)
    `UCD_ASSERT_SAME(a_idx_in_range, q_valid, idx_reg < q_entry.num_results)

endmodule

>>> hdl/utf8_codepoint_decoder.sv
// A result passes through the queue, then the output register, which sets the pace.
// Throughput: one byte per cycle, one result per cycle, while m_ready is high.
// A text that ends in a cut sequence gives two or three results for its last byte,
// which the back end sends one by one; the four-entry queue absorbs them.
// Reset (aresetn low, synchronous) empties the queue and output and closes any sequence.
module utf8_codepoint_decoder (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  utf8cd_pkg::in_t   s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output utf8cd_pkg::out_t  m_data
);

    logic                push_valid;
    logic                push_ready;
    utf8cd_pkg::entry_t  push_entry;
    logic                q_valid;
    logic                q_pop;
    utf8cd_pkg::entry_t  q_entry;

    utf8cd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    utf8cd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_entry  (push_entry),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_entry (q_entry)
    );

    utf8cd_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

>>> sim/tb_utf8_codepoint_decoder.sv
// Testbench for the UTF-8 code point decoder: directed and random byte texts, scoreboard checked.
`timescale 1ns / 1ps

module tb_utf8_codepoint_decoder;

    // Predicts the code points of every accepted byte and checks the results in order.
    class codepoint_scoreboard;
        utf8cd_pkg::out_t                expected_cps[$];
        logic [utf8cd_pkg::CP_W-1:0]     step_cps[$];
        int unsigned                     mismatches;
        logic [7:0]                      lead_byte;
        logic [1:0][7:0]                 held_bytes;
        int unsigned                     held_n;
        bit                              seq_open;

        function new();
            mismatches = 0;
            held_bytes = '0;
            close_sequence();
        endfunction

        function void close_sequence();
            seq_open  = 1'b0;
            held_n    = 0;
            lead_byte = 8'h00;
        endfunction

        // Number of bytes that follow a lead byte; zero when the byte is no lead.
        function int unsigned tail_len(logic [7:0] c);
            if (c[7:5] == 3'b110) return 1;
            if (c[7:4] == 4'b1110) return 2;
            if (c[7:3] == 5'b11110) return 3;
            return 0;
        endfunction

        // Lead payload bits followed by the low six bits of k bytes from position first.
        function logic [utf8cd_pkg::CP_W-1:0] join_bytes(logic [7:0] lead,
                                                         logic [2:0][7:0] seq_bytes,
                                                         int unsigned first, int unsigned k);
            logic [utf8cd_pkg::CP_W-1:0] v;
            if (k == 1) v = utf8cd_pkg::CP_W'(lead[4:0]);
            else if (k == 2) v = utf8cd_pkg::CP_W'(lead[3:0]);
            else v = utf8cd_pkg::CP_W'(lead[2:0]);
            for (int unsigned j = 0; j < k; j++) begin
                v = {v[utf8cd_pkg::CP_W-7:0], seq_bytes[first + j][5:0]};
            end
            return v;
        endfunction

        // At most three results come from one byte.
        function void push_cp(logic [utf8cd_pkg::CP_W-1:0] cp);
            if (step_cps.size() < 3) step_cps.push_back(cp);
        endfunction

        // Decodes the bytes left over after a cut lead as a short text of their own.
        function void decode_leftover(logic [2:0][7:0] seq_bytes, int unsigned m);
            int unsigned i;
            int unsigned kk;
            logic [7:0]  c;
            i = 0;
            while (i < m) begin
                c = seq_bytes[i];
                i++;
                if (!c[7]) begin
                    push_cp(utf8cd_pkg::CP_W'(c));
                end else begin
                    kk = tail_len(c);
                    if (kk != 0 && i + kk <= m) begin
                        push_cp(join_bytes(c, seq_bytes, i, kk));
                        i += kk;
                    end else begin
                        push_cp(utf8cd_pkg::BAD_CP);
                    end
                end
            end
        endfunction

        // Notes one accepted input transaction and queues the results it causes.
        function void accept_byte(utf8cd_pkg::in_t x);
            logic [7:0]       b;
            logic [2:0][7:0]  seq_bytes;
            int unsigned      k;
            int unsigned      hc;
            utf8cd_pkg::out_t r;
            b = x.text_byte;
            seq_bytes = '0;
            step_cps.delete();
            if (!seq_open) begin
                if (!b[7]) begin
                    push_cp(utf8cd_pkg::CP_W'(b));
                end else if (tail_len(b) == 0 || x.end_of_text) begin
                    push_cp(utf8cd_pkg::BAD_CP);
                end else begin
                    seq_open  = 1'b1;
                    lead_byte = b;
                    held_n    = 0;
                end
            end else begin
                k  = tail_len(lead_byte);
                hc = held_n;
                for (int unsigned j = 0; j < hc; j++) seq_bytes[j] = held_bytes[j];
                seq_bytes[hc] = b;
                if (hc + 1 >= k) begin
                    push_cp(join_bytes(lead_byte, seq_bytes, 0, k));
                    close_sequence();
                end else if (x.end_of_text) begin
                    // The text ends inside the sequence: the lead is bad, the rest decodes anew.
                    push_cp(utf8cd_pkg::BAD_CP);
                    decode_leftover(seq_bytes, hc + 1);
                    close_sequence();
                end else begin
                    held_bytes[hc] = b;
                    held_n = hc + 1;
                end
            end
            if (x.end_of_text) close_sequence();
            foreach (step_cps[i]) begin
                r.code_point = step_cps[i];
                r.run_end    = (i == step_cps.size() - 1);
                r.text_done  = (i == step_cps.size() - 1) && x.end_of_text;
                expected_cps.push_back(r);
            end
        endfunction

        // Compares one result transaction with the oldest expectation.
        function void compare_code_point(utf8cd_pkg::out_t got);
            utf8cd_pkg::out_t want;
            if (expected_cps.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, got cp=%h run_end=%b done=%b",
                         $time, got.code_point, got.run_end, got.text_done);
                return;
            end
            want = expected_cps.pop_front();
            if (got.code_point !== want.code_point) begin
                mismatches++;
                $display("%0t: code_point expected %h, got %h",
                         $time, want.code_point, got.code_point);
            end
            if (got.run_end !== want.run_end) begin
                mismatches++;
                $display("%0t: run_end expected %b, got %b", $time, want.run_end, got.run_end);
            end
            if (got.text_done !== want.text_done) begin
                mismatches++;
                $display("%0t: text_done expected %b, got %b",
                         $time, want.text_done, got.text_done);
            end
        endfunction
    endclass

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    utf8cd_pkg::in_t  s_data;
    logic             m_valid;
    logic             m_ready;
    utf8cd_pkg::out_t m_data;

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    codepoint_scoreboard sb = new();

    utf8_codepoint_decoder u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Clock generation.
    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // The receiver stalls at random, changing ready on the falling edge.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Every accepted result transaction goes to the scoreboard.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.compare_code_point(m_data);
        end
    end

    // Sends one byte, idling at random first, and waits until it is accepted.
    task automatic send_byte(input logic [7:0] b, input bit eot);
        utf8cd_pkg::in_t x;
        x.text_byte   = b;
        x.end_of_text = eot;
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= x;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.accept_byte(x);
    endtask

    // Holds the sender back until every expected result has come out.
    task automatic wait_for_drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.expected_cps.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] tail_byte();
        if ($urandom_range(0, 3) == 0) return 8'($urandom);
        return {2'b10, 6'($urandom)};
    endfunction

    // Random texts built mostly from well-formed sequences, some cut short or with noise.
    task automatic send_random_texts(input int unsigned n_bytes);
        logic [7:0]  text_bytes[$];
        logic [7:0]  tok[$];
        int unsigned sent;
        int unsigned n_tok;
        int unsigned n_tail;
        int unsigned keep;
        sent = 0;
        while (sent < n_bytes) begin
            text_bytes.delete();
            n_tok = $urandom_range(1, 6);
            for (int unsigned t = 0; t < n_tok; t++) begin
                tok.delete();
                n_tail = 0;
                case ($urandom_range(0, 9)) inside
                    [0:2]: tok.push_back(8'($urandom_range(0, 127)));
                    [3:4]: begin
                        tok.push_back({3'b110, 5'($urandom)});
                        n_tail = 1;
                    end
                    [5:6]: begin
                        tok.push_back({4'b1110, 4'($urandom)});
                        n_tail = 2;
                    end
                    [7:8]: begin
                        tok.push_back({5'b11110, 3'($urandom)});
                        n_tail = 3;
                    end
                    default: tok.push_back(8'($urandom));
                endcase
                for (int unsigned j = 0; j < n_tail; j++) tok.push_back(tail_byte());
                // Now and then the text ends inside its last sequence.
                if (t == n_tok - 1 && tok.size() > 1 && $urandom_range(0, 3) == 0) begin
                    keep = $urandom_range(1, tok.size() - 1);
                    while (tok.size() > keep) void'(tok.pop_back());
                end
                foreach (tok[j]) text_bytes.push_back(tok[j]);
            end
            foreach (text_bytes[i]) begin
                send_byte(text_bytes[i], i == text_bytes.size() - 1);
                sent++;
            end
        end
    endtask

    // Main sequence: reset, directed texts, then three random phases.
    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        send_idle_pct = 14;
        recv_idle_pct = 48;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // ASCII extremes and complete sequences of every length.
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hDF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b0);
        send_byte(8'hF7, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        // A continuation byte and 0xF8..0xFF as lead are bad.
        send_byte(8'h80, 1'b0);
        send_byte(8'hF8, 1'b0);
        send_byte(8'hFF, 1'b0);
        // A lead byte as the final byte.
        send_byte(8'hC3, 1'b1);
        // Cut four-byte sequence whose held bytes form a two-byte sequence.
        send_byte(8'hF0, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b1);
        // Cut three-byte sequence followed by ASCII.
        send_byte(8'hE2, 1'b0);
        send_byte(8'h41, 1'b1);
        // The final byte completes a sequence.
        send_byte(8'hC2, 1'b0);
        send_byte(8'hFF, 1'b1);
        // A one-byte text.
        send_byte(8'h41, 1'b1);

        wait_for_drain();
        send_random_texts(32);

        send_idle_pct = 48;
        recv_idle_pct = 14;
        wait_for_drain();
        send_random_texts(32);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random_texts(32);

        wait_for_drain();
        repeat (10) @(posedge aclk);
        if (sb.mismatches == 0 && sb.expected_cps.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, sb.expected_cps.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> utf8_codepoint_decoder.f
+incdir+hdl
hdl/utf8cd_pkg.sv
hdl/utf8cd_front.sv
hdl/utf8cd_queue.sv
hdl/utf8cd_back.sv
hdl/utf8_codepoint_decoder.sv
sim/tb_utf8_codepoint_decoder.sv
